[design/edd_pkg.sv]
`default_nettype none

package edd_pkg;

    // Line store geometry
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int SIZE_W     = 13;
    localparam int BITS_W     = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEPT_BITS    = 2'd2;

    localparam logic [SIZE_W-1:0] RST_IMAGE_WIDTH  = 13'd1024;
    localparam logic [SIZE_W-1:0] RST_IMAGE_HEIGHT = 13'd768;
    localparam logic [BITS_W-1:0] RST_KEPT_BITS    = 4'd8;

    // Channel order: [2] red, [1] green, [0] blue
    typedef logic [2:0][7:0] t_rgb;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       frame_end;
    } t_pix_out;

endpackage

`default_nettype wire

[design/error_diffusion_dither.sv]
// Flow: an accepted pixel is registered in the compute stage, then in the output register.
// Throughput: one pixel per cycle unless output stalls; the line store takes
//   one read (issued at accept) and one write per cycle, extra last-column write deferred.
// Reset (synchronous, active low): counters, carries, pipeline valids and the
//   configuration registers return to their defaults. The line store is not
//   cleared; the first row of a frame never uses what it reads from it.
`default_nettype none

module error_diffusion_dither
    import edd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // pixel input
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_pix_in               i_in_data,
    // pixel output
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_pix_out                   o_out_data,
    // configuration
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CNT_W = COL_W + 1;
    localparam int RCN_W = ROW_W + 1;

    function automatic logic [7:0] sat8(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[8] ? 8'hFF : s[7:0];
    endfunction

    // configuration registers
    logic [SIZE_W-1:0] r_cfg_width;
    logic [SIZE_W-1:0] r_cfg_height;
    logic [BITS_W-1:0] r_cfg_bits;

    // accept-side position
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    // compute stage
    logic             r_s1_vld;
    t_rgb             r_s1_pix;
    logic [COL_W-1:0] r_s1_x;
    logic             r_s1_y_nz;
    logic             r_s1_lastc;
    logic             r_s1_lastr;
    t_rgb             r_rd;
    logic             r_fwd_hit;
    t_rgb             r_fwd_data;

    // diffusion state
    t_rgb r_rc, n_rc;
    t_rgb r_pbh, n_pbh;
    t_rgb r_pbn, n_pbn;

    // deferred last-column write
    logic             r_pend_vld, n_pend_vld;
    logic [COL_W-1:0] r_pend_addr;
    t_rgb             r_pend_data, n_pend_data;

    // output register
    logic     r_o_vld;
    t_pix_out r_o_data, n_o_data;

    // line store
    t_rgb line_mem [MAX_WIDTH];

    logic [CNT_W-1:0] w_eff;
    logic [RCN_W-1:0] h_eff;
    logic [2:0]       nb_eff;
    logic             pass;
    logic [7:0]       low_mask;
    logic             in_acc, s1_fire;
    logic             acc_lastc, acc_lastr;
    logic             dir_we;
    logic [COL_W-1:0] dir_addr;
    t_rgb             dir_data;
    logic             mem_we;
    logic [COL_W-1:0] mem_waddr;
    t_rgb             mem_wdata;
    logic             fwd_hit;
    t_rgb             fwd_data;
    t_rgb             above, q, e, here_new;
    t_rgb             sh_r, sh_bl, sh_b, sh_br;
    logic [10:0]      p7, p3, p5;

    // effective geometry and quantizer
    always_comb begin
        if (r_cfg_width == '0) begin
            w_eff = CNT_W'(1);
        end else if (int'(r_cfg_width) > MAX_WIDTH) begin
            w_eff = CNT_W'(MAX_WIDTH);
        end else begin
            w_eff = CNT_W'(r_cfg_width);
        end
        if (r_cfg_height == '0) begin
            h_eff = RCN_W'(1);
        end else if (int'(r_cfg_height) > MAX_HEIGHT) begin
            h_eff = RCN_W'(MAX_HEIGHT);
        end else begin
            h_eff = RCN_W'(r_cfg_height);
        end
        pass     = (r_cfg_bits >= 4'd8);
        nb_eff   = (r_cfg_bits == '0) ? 3'd1 : r_cfg_bits[2:0];
        low_mask = 8'hFF >> nb_eff;
    end

    assign s1_fire    = r_s1_vld && (!r_o_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || s1_fire;
    assign in_acc     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    assign acc_lastc = (CNT_W'(r_col) + CNT_W'(1)) >= w_eff;
    assign acc_lastr = (RCN_W'(r_row) + RCN_W'(1)) >= h_eff;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (in_acc) begin
            if (acc_lastc) begin
                n_col = '0;
                n_row = acc_lastr ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    // per-channel diffusion
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (!r_s1_y_nz) begin
                above[c] = 8'd0;
            end else if (r_fwd_hit) begin
                above[c] = r_fwd_data[c];
            end else begin
                above[c] = r_rd[c];
            end
            if (pass) begin
                q[c] = r_s1_pix[c];
                e[c] = 8'd0;
            end else begin
                q[c] = sat8(r_s1_pix[c], sat8(r_rc[c], above[c])) & ~low_mask;
                e[c] = sat8(r_s1_pix[c], sat8(r_rc[c], above[c])) & low_mask;
            end
            p7 = {3'b0, e[c]} * 11'd7;
            p3 = {3'b0, e[c]} * 11'd3;
            p5 = {3'b0, e[c]} * 11'd5;
            sh_r[c]  = {1'b0, p7[10:4]};
            sh_bl[c] = {1'b0, p3[10:4]};
            sh_b[c]  = {1'b0, p5[10:4]};
            sh_br[c] = {4'b0, e[c][7:4]};
            here_new[c] = sat8(r_pbn[c], sh_b[c]);
            dir_data[c] = sat8(r_pbh[c], sh_bl[c]);
        end
    end

    always_comb begin
        n_rc        = r_rc;
        n_pbh       = r_pbh;
        n_pbn       = r_pbn;
        n_pend_vld  = 1'b0;
        n_pend_data = here_new;
        dir_we      = 1'b0;
        dir_addr    = r_s1_x - 1'b1;
        if (s1_fire) begin
            n_rc = r_s1_lastc ? '0 : sh_r;
            if (!r_s1_lastr) begin
                dir_we     = (r_s1_x != '0);
                n_pend_vld = r_s1_lastc;
                n_pbh      = r_s1_lastc ? '0 : here_new;
                n_pbn      = r_s1_lastc ? '0 : sh_br;
            end else begin
                n_pbh = '0;
                n_pbn = '0;
            end
        end
        n_o_data.out_red   = q[2];
        n_o_data.out_green = q[1];
        n_o_data.out_blue  = q[0];
        n_o_data.frame_end = r_s1_lastc && r_s1_lastr;
    end

    // one write port: the deferred write lands in a cycle whose pixel, if any, is column 0
    always_comb begin
        mem_we    = r_pend_vld || dir_we;
        mem_waddr = r_pend_vld ? r_pend_addr : dir_addr;
        mem_wdata = r_pend_vld ? r_pend_data : dir_data;
    end

    // bypass writes landing with the read, and the one being deferred; newest first
    always_comb begin
        fwd_hit  = 1'b1;
        fwd_data = n_pend_data;
        if (n_pend_vld && r_s1_x == r_col) begin
            fwd_data = n_pend_data;
        end else if (dir_we && dir_addr == r_col) begin
            fwd_data = dir_data;
        end else if (r_pend_vld && r_pend_addr == r_col) begin
            fwd_data = r_pend_data;
        end else begin
            fwd_hit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            line_mem[mem_waddr] <= mem_wdata;
        end
        if (in_acc) begin
            r_rd <= line_mem[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= RST_IMAGE_WIDTH;
            r_cfg_height <= RST_IMAGE_HEIGHT;
            r_cfg_bits   <= RST_KEPT_BITS;
            r_col        <= '0;
            r_row        <= '0;
            r_s1_vld     <= 1'b0;
            r_rc         <= '0;
            r_pbh        <= '0;
            r_pbn        <= '0;
            r_pend_vld   <= 1'b0;
            r_o_vld      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data[SIZE_W-1:0];
                    CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data[SIZE_W-1:0];
                    CFG_KEPT_BITS:    r_cfg_bits   <= i_cfg_data[BITS_W-1:0];
                    default: ;
                endcase
            end
            r_col      <= n_col;
            r_row      <= n_row;
            r_rc       <= n_rc;
            r_pbh      <= n_pbh;
            r_pbn      <= n_pbn;
            r_pend_vld <= n_pend_vld;
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_fire) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_fire) begin
                r_o_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix   <= {i_in_data.in_red, i_in_data.in_green, i_in_data.in_blue};
            r_s1_x     <= r_col;
            r_s1_y_nz  <= (r_row != '0);
            r_s1_lastc <= acc_lastc;
            r_s1_lastr <= acc_lastr;
            r_fwd_hit  <= fwd_hit;
            r_fwd_data <= fwd_data;
        end
        if (n_pend_vld) begin
            r_pend_addr <= r_s1_x;
            r_pend_data <= n_pend_data;
        end
        if (s1_fire) begin
            r_o_data <= n_o_data;
        end
    end

    assign o_out_valid = r_o_vld;
    assign o_out_data  = r_o_data;

endmodule

`default_nettype wire

[design/edd_chk.sv]
`default_nettype none

module edd_chk
    import edd_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  o_in_ready,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_ready,
    input wire t_pix_out              o_out_data
);

    // pixels in flight, seen from the ports
    logic [1:0] r_cnt;
    logic       in_acc, out_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_acc && !out_acc) begin
            r_cnt <= r_cnt + 2'd1;
        end else if (out_acc && !in_acc) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output request dropped or changed while stalled");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without output backpressure");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_cnt != 2'd0)
        else $error("output request with no pixel in flight");

    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !in_acc || out_acc)
        else $error("more than two pixels in flight");

endmodule

bind error_diffusion_dither edd_chk u_edd_chk (.*);

`default_nettype wire
